// ===== sv/gcode_line_number_checksum_check_defines.svh =====
// Assertion helpers for the line checksum checker.
`ifndef GCODE_LINE_NUMBER_CHECKSUM_CHECK_DEFINES_SVH
`define GCODE_LINE_NUMBER_CHECKSUM_CHECK_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GCLC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gclc assertion failed");

// next-cycle implication, disabled in reset
`define GCLC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gclc assertion failed");

`endif

// ===== sv/gclc_pkg.sv =====
package gclc_pkg;

  localparam int LINE_W = 32;
  localparam int SUM_W  = 10;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_NUMBER   = 3'd1,
    ST_NO_NUMBER    = 3'd2,
    ST_NO_CHECKSUM  = 3'd3,
    ST_BAD_CHECKSUM = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic                accepted;
    logic [LINE_W-1:0]   line;
  } verdict_t;

endpackage

// ===== sv/gclc_ifs.sv =====
// character stream in
interface gclc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// one verdict per line
interface gclc_result_if;
  logic                       valid;
  logic                       ready;
  gclc_pkg::status_t          status;
  logic                       line_accepted;
  logic [gclc_pkg::LINE_W-1:0] checked_line_number;

  modport source (output valid, output status, output line_accepted,
                  output checked_line_number, input ready);
  modport sink   (input valid, input status, input line_accepted,
                  input checked_line_number, output ready);
endinterface

// strict mode register write
interface gclc_cfg_if;
  logic valid;
  logic ready;
  logic strict_mode;

  modport source (output valid, output strict_mode, input ready);
  modport sink   (input valid, input strict_mode, output ready);
endinterface

// ===== sv/gcode_line_number_checksum_check.sv =====
// Checks line numbers and XOR checksums of a received G-code stream
// ("N<num> ... *<xor>"), one byte per chars transaction. CR or LF closes a
// line and produces one results transaction with the status, an accept flag
// and the line number that was expected; other bytes produce nothing. Every
// accepted line, blank ones too, advances the expected number (wraps at
// 2^32). With strict_mode set, lines lacking a number or a checksum fail;
// CR LF counts as two lines. Throughput is one byte per cycle while no
// terminator stalls: a byte is registered, then parsed and, for a
// terminator, its verdict registered into the result register, which
// drives results.valid. The only stall is a terminator waiting for a full
// result register. strict_mode is to be written by the user through cfg,
// only while the block is idle; the block itself does not enforce this.
module gcode_line_number_checksum_check (
  input  logic        clk,
  input  logic        rst,
  gclc_char_if.sink   chars,
  gclc_result_if.source results,
  gclc_cfg_if.sink    cfg
);
  import gclc_pkg::*;

  logic       strict;

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_term;
  logic       s1_go;

  verdict_t   verdict;

  // result register
  logic       out_valid;
  verdict_t   out_verdict;

  // config: always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict <= 1'b0;
    end else if (cfg.valid) begin
      strict <= cfg.strict_mode;
    end
  end

  // A plain byte never needs the result slot; a terminator moves on only
  // when the result register is free or drains this cycle.
  assign s1_term    = (s1_char == CH_CR) || (s1_char == CH_LF);
  assign s1_go      = s1_valid && (!s1_term || !out_valid || results.ready);
  assign chars.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s1_char <= chars.character;
    end
  end

  gclc_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .ch      (s1_char),
    .strict  (strict),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_term) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && s1_term) begin
      out_verdict <= verdict;
    end
  end

  assign results.valid               = out_valid;
  assign results.status              = out_verdict.status;
  assign results.line_accepted       = out_verdict.accepted;
  assign results.checked_line_number = out_verdict.line;

endmodule

// ===== sv/gclc_scan.sv =====
// Per-line parse state and verdict for one character per step.
module gclc_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         ch,
  input  logic               strict,
  output gclc_pkg::verdict_t verdict
);
  import gclc_pkg::*;

  logic [LINE_W-1:0] expected_line;
  logic [7:0]        running_xor;
  logic [7:0]        xor_at_star;
  logic              star_seen;
  logic [SUM_W-1:0]  sum_digits_value;
  logic              sum_digits_open;
  logic              number_tag_seen;
  logic [LINE_W-1:0] tag_digits_value;
  logic              tag_digits_open;
  logic              at_line_start;

  logic              is_term;
  logic              is_digit;
  logic [3:0]        digit;
  logic [LINE_W-1:0] tag_next;
  logic [SUM_W+3:0]  sum_wide;
  logic [SUM_W-1:0]  sum_next;
  status_t           status;

  assign is_term  = (ch == CH_CR) || (ch == CH_LF);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit    = 4'(ch - CH_ZERO);

  // x*10 = x*8 + x*2, wraps mod 2^32
  assign tag_next = {tag_digits_value[LINE_W-4:0], 3'b000}
                  + {tag_digits_value[LINE_W-2:0], 1'b0}
                  + LINE_W'(digit);

  assign sum_wide = {1'b0, sum_digits_value, 3'b000}
                  + {3'b000, sum_digits_value, 1'b0}
                  + (SUM_W+4)'(digit);
  assign sum_next = (sum_wide > (SUM_W+4)'(SUM_LIMIT)) ? SUM_LIMIT
                                                       : sum_wide[SUM_W-1:0];

  always_comb begin
    status = ST_OK;
    if (number_tag_seen) begin
      if (tag_digits_value != expected_line) status = ST_BAD_NUMBER;
    end else if (strict) begin
      status = ST_NO_NUMBER;
    end
    if (status == ST_OK && strict && !star_seen) status = ST_NO_CHECKSUM;
    if (status == ST_OK && star_seen && {2'b00, xor_at_star} != sum_digits_value) begin
      status = ST_BAD_CHECKSUM;
    end
  end

  assign verdict.status   = status;
  assign verdict.accepted = (status == ST_OK);
  assign verdict.line     = expected_line;

  always_ff @(posedge clk) begin
    if (rst || (step && is_term)) begin
      running_xor      <= '0;
      xor_at_star      <= '0;
      star_seen        <= 1'b0;
      sum_digits_value <= '0;
      sum_digits_open  <= 1'b0;
      number_tag_seen  <= 1'b0;
      tag_digits_value <= '0;
      tag_digits_open  <= 1'b0;
      at_line_start    <= 1'b1;
    end else if (step) begin
      if (at_line_start && ch == CH_N) begin
        number_tag_seen  <= 1'b1;
        tag_digits_open  <= 1'b1;
        tag_digits_value <= '0;
      end else if (tag_digits_open) begin
        if (is_digit) tag_digits_value <= tag_next;
        else          tag_digits_open  <= 1'b0;
      end

      if (ch == CH_STAR) begin
        star_seen        <= 1'b1;
        xor_at_star      <= running_xor;
        sum_digits_value <= '0;
        sum_digits_open  <= 1'b1;
      end else if (sum_digits_open) begin
        if (is_digit) sum_digits_value <= sum_next;
        else          sum_digits_open  <= 1'b0;
      end

      running_xor   <= running_xor ^ ch;
      at_line_start <= 1'b0;
    end

    if (rst) begin
      expected_line <= '0;
    end else if (step && is_term && status == ST_OK) begin
      expected_line <= expected_line + LINE_W'(1);
    end
  end

endmodule

// ===== sv/gclc_checker.sv =====
`include "gcode_line_number_checksum_check_defines.svh"

module gclc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input gclc_pkg::status_t            res_status,
  input logic                         res_accepted,
  input logic [gclc_pkg::LINE_W-1:0]  res_line
);
  import gclc_pkg::*;

  // line number the next verdict must carry
  logic [LINE_W-1:0] pred_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_line <= '0;
    end else if (res_valid && res_ready && res_accepted) begin
      pred_line <= res_line + LINE_W'(1);
    end
  end

  `GCLC_ASSERT_IMP(a_accept_iff_ok, clk, rst, res_valid,
                   res_accepted == (res_status == ST_OK))
  `GCLC_ASSERT_IMP(a_line_sequence, clk, rst, res_valid, res_line == pred_line)
  `GCLC_ASSERT_NXT(a_stall_hold, clk, rst, res_valid && !res_ready,
                   res_valid && $stable(res_status) && $stable(res_accepted) && $stable(res_line))

endmodule

bind gcode_line_number_checksum_check gclc_checker u_gclc_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .res_status   (results.status),
  .res_accepted (results.line_accepted),
  .res_line     (results.checked_line_number)
);
